>>> rtl/core/kmeans_centroid_update_core_macros.svh
// Assertion macros shared by the k-means centroid update RTL.
`ifndef KMEANS_CENTROID_UPDATE_CORE_MACROS_SVH
`define KMEANS_CENTROID_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define KMCU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define KMCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/kmcu_pkg.sv
// Types and constants of the k-means centroid update core.
package kmcu_pkg;

    localparam int COORD_W   = 16;   // Q4.11 coordinate
    localparam int SUM_W     = 32;   // coordinate sum
    localparam int IDX_OUT_W = 6;    // cluster field on the ports
    localparam int NC_W      = 7;    // num_clusters register
    localparam int REM_W     = 17;   // divider partial remainder
    localparam int QUO_STEPS = 16;   // quotient bits, one per cycle
    localparam int STEP_W    = 4;    // counts QUO_STEPS
    localparam int LANES     = 3;    // x, y, z

    localparam logic [NC_W-1:0] NC_RST = 7'd16;

    // Register addresses
    localparam logic [0:0] REG_NUM_CLUSTERS = 1'b0;

    // Command codes
    localparam logic [1:0] CMD_ACC    = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    typedef enum logic [2:0] {
        ST_RUN,   // take points, loads and finish commands
        ST_RD,    // issue reads for the current cluster
        ST_LD,    // load divider lanes from read data
        ST_DIV,   // one quotient bit per cycle
        ST_OUT    // hand the new center to the output register
    } state_t;

endpackage

>>> rtl/core/kmcu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kmcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/kmeans_centroid_update_core.sv
// Top level of the k-means centroid update core for 3-D Q4.11 points.
//
// Input stream (s_*): one transfer carries a command in s_tuser (accumulate,
// finish, load) with a cluster number and a point in s_tdata. Accumulate
// adds the point to that cluster's sums and member count; load sets the
// cluster's stored center. Both are accepted back to back: the sum memory
// is read at accept and written in the following cycle, and a one-entry
// forward path covers a read of the entry being written.
// Finish walks clusters 0..k-1. Per cluster: a read state, a load state, the
// three-lane restoring divider (one quotient bit per cycle) and an output
// state. Input is held off during the pass, and the last output of the pass
// clears the sum valid bits.
// Output stream (m_*): one transfer per cluster with index and new center in
// m_tdata, m_tlast on the last cluster and m_tuser set there if any center
// moved. The output register holds its result while m_tready is low; the
// walk pauses until the slot frees.
// Configuration: num_clusters at address 0 over the APB port. The user must
// write it only while the block is idle; the block itself does not enforce it.
// Reset sets it to 16 and clears the valid bits of both memories, so every
// sum, count and center reads as zero without a clearing pass.
`include "kmeans_centroid_update_core_macros.svh"

module kmeans_centroid_update_core #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_POINTS   = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // cluster[5:0], point_x[21:6], point_y[37:22],
                                   // point_z[53:38], zero fill [55:54]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // center_index[5:0], center_x[21:6],
                                   // center_y[37:22], center_z[53:38], zero fill
    output logic [0:0]  m_tuser,   // any_changed[0]
    output logic        m_tlast,   // last_center
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CW     = kmcu_pkg::COORD_W;
    localparam int SW     = kmcu_pkg::SUM_W;
    localparam int SUMS_W = 3 * SW + CNT_W;
    localparam int CTR_W  = 3 * CW;
    localparam logic [CNT_W-1:0]         CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [kmcu_pkg::NC_W-1:0] K_MAX  = kmcu_pkg::NC_W'(MAX_CLUSTERS);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [kmcu_pkg::NC_W-1:0] nc_reg;
    logic [kmcu_pkg::NC_W-1:0] k_eff;

    assign pready = 1'b1;
    assign prdata = (paddr == kmcu_pkg::REG_NUM_CLUSTERS) ? 32'(nc_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= kmcu_pkg::NC_RST;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == kmcu_pkg::REG_NUM_CLUSTERS)
        begin
            nc_reg <= pwdata[kmcu_pkg::NC_W-1:0];
        end
    end

    // Clamp k to 1..MAX_CLUSTERS.
    always_comb
    begin
        if (nc_reg == '0)
        begin
            k_eff = kmcu_pkg::NC_W'(1);
        end
        else if (nc_reg > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = nc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and command decode
    // ------------------------------------------------------------------
    logic [1:0]                       s_cmd;
    logic [kmcu_pkg::IDX_OUT_W-1:0]   s_cluster;
    logic [CW-1:0]                    s_pt [kmcu_pkg::LANES];
    logic                             s_fire;
    logic                             in_range;
    logic                             acc_go;
    logic                             ld_go;
    logic                             fin_go;

    assign s_cmd     = s_tuser;
    assign s_cluster = s_tdata[5:0];
    assign s_pt[0]   = s_tdata[21:6];
    assign s_pt[1]   = s_tdata[37:22];
    assign s_pt[2]   = s_tdata[53:38];

    assign s_fire   = s_tvalid && s_tready;
    assign in_range = {1'b0, s_cluster} < k_eff;
    assign acc_go   = s_fire && (s_cmd == kmcu_pkg::CMD_ACC) && in_range;
    assign ld_go    = s_fire && (s_cmd == kmcu_pkg::CMD_LOAD) && in_range;
    assign fin_go   = s_fire && (s_cmd == kmcu_pkg::CMD_FINISH);

    // ------------------------------------------------------------------
    // Control state machine
    // ------------------------------------------------------------------
    kmcu_pkg::state_t state_reg;
    kmcu_pkg::state_t state_next;

    logic [IDX_W-1:0]            idx_reg;
    logic [kmcu_pkg::STEP_W-1:0] step_reg;
    logic                        out_vld_reg;
    logic                        out_ok;
    logic                        is_last;

    logic rd_issue;
    logic lanes_load;
    logic div_step;
    logic out_load;
    logic clear_sums;

    assign out_ok  = !out_vld_reg || m_tready;
    assign is_last = (kmcu_pkg::NC_W'(idx_reg) + kmcu_pkg::NC_W'(1)) == k_eff;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmcu_pkg::ST_RUN:
            begin
                if (fin_go)
                begin
                    state_next = kmcu_pkg::ST_RD;
                end
            end
            kmcu_pkg::ST_RD:
            begin
                state_next = kmcu_pkg::ST_LD;
            end
            kmcu_pkg::ST_LD:
            begin
                state_next = kmcu_pkg::ST_DIV;
            end
            kmcu_pkg::ST_DIV:
            begin
                if (step_reg == kmcu_pkg::STEP_W'(kmcu_pkg::QUO_STEPS - 1))
                begin
                    state_next = kmcu_pkg::ST_OUT;
                end
            end
            kmcu_pkg::ST_OUT:
            begin
                if (out_ok)
                begin
                    state_next = is_last ? kmcu_pkg::ST_RUN : kmcu_pkg::ST_RD;
                end
            end
            default:
            begin
                state_next = kmcu_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        rd_issue   = 1'b0;
        lanes_load = 1'b0;
        div_step   = 1'b0;
        out_load   = 1'b0;
        clear_sums = 1'b0;
        unique case (state_reg)
            kmcu_pkg::ST_RUN: s_tready   = 1'b1;
            kmcu_pkg::ST_RD:  rd_issue   = 1'b1;
            kmcu_pkg::ST_LD:  lanes_load = 1'b1;
            kmcu_pkg::ST_DIV: div_step   = 1'b1;
            kmcu_pkg::ST_OUT:
            begin
                out_load   = out_ok;
                clear_sums = out_ok && is_last;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmcu_pkg::ST_RUN;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                idx_reg <= '0;
            end
            else if (out_load && !is_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (lanes_load)
            begin
                step_reg <= '0;
            end
            else if (div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum memory: {sum_z, sum_y, sum_x, member_count} per cluster
    // ------------------------------------------------------------------
    logic                    sum_we;
    logic [IDX_W-1:0]        sum_waddr;
    logic [SUMS_W-1:0]       sum_wdata;
    logic                    sum_re;
    logic [IDX_W-1:0]        sum_raddr;
    logic [SUMS_W-1:0]       sum_rdata;
    logic [MAX_CLUSTERS-1:0] sum_vld_reg;
    logic [IDX_W-1:0]        rd_addr_reg;

    // Last write, forwarded to a read of the same entry issued in that cycle.
    logic                    fwd_vld_reg;
    logic [IDX_W-1:0]        fwd_addr_reg;
    logic [SUMS_W-1:0]       fwd_data_reg;

    logic [SUMS_W-1:0]       sum_cur;
    logic [CNT_W-1:0]        cnt_cur;
    logic [SW-1:0]           sum_lane [kmcu_pkg::LANES];

    // Accumulate stage: point waiting for its sums to come back.
    logic                    acc_vld_reg;
    logic [CW-1:0]           acc_pt_reg [kmcu_pkg::LANES];

    assign sum_re    = acc_go || rd_issue;
    assign sum_raddr = rd_issue ? idx_reg : s_cluster[IDX_W-1:0];

    always_comb
    begin
        if (!sum_vld_reg[rd_addr_reg])
        begin
            sum_cur = '0;
        end
        else if (fwd_vld_reg && fwd_addr_reg == rd_addr_reg)
        begin
            sum_cur = fwd_data_reg;
        end
        else
        begin
            sum_cur = sum_rdata;
        end
    end

    assign cnt_cur     = sum_cur[CNT_W-1:0];
    assign sum_lane[0] = sum_cur[CNT_W +: SW];
    assign sum_lane[1] = sum_cur[CNT_W + SW +: SW];
    assign sum_lane[2] = sum_cur[CNT_W + 2 * SW +: SW];

    // Drop the point once the count is full.
    assign sum_we    = acc_vld_reg && (cnt_cur < CNT_MAX);
    assign sum_waddr = rd_addr_reg;
    assign sum_wdata = {
        sum_lane[2] + {{(SW - CW){acc_pt_reg[2][CW-1]}}, acc_pt_reg[2]},
        sum_lane[1] + {{(SW - CW){acc_pt_reg[1][CW-1]}}, acc_pt_reg[1]},
        sum_lane[0] + {{(SW - CW){acc_pt_reg[0][CW-1]}}, acc_pt_reg[0]},
        cnt_cur + 1'b1
    };

    kmcu_ram #(
        .WIDTH (SUMS_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= '0;
            fwd_vld_reg <= 1'b0;
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= acc_go;
            if (clear_sums)
            begin
                sum_vld_reg <= '0;
                fwd_vld_reg <= 1'b0;
            end
            else if (sum_we)
            begin
                sum_vld_reg[sum_waddr] <= 1'b1;
                fwd_vld_reg            <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_re)
        begin
            rd_addr_reg <= sum_raddr;
        end
        if (acc_go)
        begin
            acc_pt_reg <= s_pt;
        end
        if (sum_we)
        begin
            fwd_addr_reg <= sum_waddr;
            fwd_data_reg <= sum_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Center memory: {z, y, x} per cluster
    // ------------------------------------------------------------------
    logic                    ctr_we;
    logic [IDX_W-1:0]        ctr_waddr;
    logic [CTR_W-1:0]        ctr_wdata;
    logic [CTR_W-1:0]        ctr_rdata;
    logic [CTR_W-1:0]        ctr_cur;
    logic [MAX_CLUSTERS-1:0] ctr_vld_reg;
    logic [CW-1:0]           new_ctr [kmcu_pkg::LANES];

    assign ctr_we    = ld_go || out_load;
    assign ctr_waddr = ld_go ? s_cluster[IDX_W-1:0] : idx_reg;
    assign ctr_wdata = ld_go ? {s_pt[2], s_pt[1], s_pt[0]}
                             : {new_ctr[2], new_ctr[1], new_ctr[0]};
    assign ctr_cur   = ctr_vld_reg[idx_reg] ? ctr_rdata : '0;

    kmcu_ram #(
        .WIDTH (CTR_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (rd_issue),
        .raddr (idx_reg),
        .rdata (ctr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_vld_reg <= '0;
        end
        else if (ctr_we)
        begin
            ctr_vld_reg[ctr_waddr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Three-lane restoring divider: |sum| / count, one bit per cycle.
    // The mean of Q4.11 values stays below 2^16, so the top 16 dividend
    // bits seed the remainder and only 16 steps remain.
    // ------------------------------------------------------------------
    logic [kmcu_pkg::REM_W-1:0] rem_reg  [kmcu_pkg::LANES];
    logic [kmcu_pkg::REM_W-1:0] rem_next [kmcu_pkg::LANES];
    logic [CW-1:0]              quo_reg  [kmcu_pkg::LANES];
    logic [CW-1:0]              quo_next [kmcu_pkg::LANES];
    logic [CW-1:0]              old_reg  [kmcu_pkg::LANES];
    logic [SW-1:0]              mag      [kmcu_pkg::LANES];
    logic [kmcu_pkg::LANES-1:0] neg_reg;
    logic [kmcu_pkg::REM_W-1:0] div_reg;
    logic                       empty_reg;
    logic [kmcu_pkg::LANES-1:0] lane_chg;
    logic                       chg;

    always_comb
    begin
        logic [kmcu_pkg::REM_W:0] trial;
        logic                     ge;
        for (int l = 0; l < kmcu_pkg::LANES; l++)
        begin
            mag[l] = sum_lane[l][SW-1] ? (SW'(0) - sum_lane[l]) : sum_lane[l];

            trial       = {rem_reg[l], quo_reg[l][CW-1]};
            ge          = trial >= {1'b0, div_reg};
            rem_next[l] = ge ? kmcu_pkg::REM_W'(trial - {1'b0, div_reg})
                             : trial[kmcu_pkg::REM_W-1:0];
            quo_next[l] = {quo_reg[l][CW-2:0], ge};

            // Empty cluster keeps its stored center.
            if (empty_reg)
            begin
                new_ctr[l] = old_reg[l];
            end
            else
            begin
                new_ctr[l] = neg_reg[l] ? (CW'(0) - quo_reg[l]) : quo_reg[l];
            end
            lane_chg[l] = new_ctr[l] != old_reg[l];
        end
    end

    assign chg = |lane_chg;

    always_ff @(posedge clk)
    begin
        if (lanes_load)
        begin
            for (int l = 0; l < kmcu_pkg::LANES; l++)
            begin
                rem_reg[l] <= kmcu_pkg::REM_W'(mag[l][SW-1:CW]);
                quo_reg[l] <= mag[l][CW-1:0];
                neg_reg[l] <= sum_lane[l][SW-1];
                old_reg[l] <= ctr_cur[l * CW +: CW];
            end
            div_reg   <= kmcu_pkg::REM_W'(cnt_cur);
            empty_reg <= cnt_cur == '0;
        end
        else if (div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                 chg_acc_reg;
    logic                 out_last_reg;
    logic                 out_chg_reg;
    logic [53:0]          out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            chg_acc_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (fin_go)
            begin
                chg_acc_reg <= 1'b0;
            end
            else if (out_load)
            begin
                chg_acc_reg <= chg_acc_reg || chg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {new_ctr[2], new_ctr[1], new_ctr[0],
                             kmcu_pkg::IDX_OUT_W'(idx_reg)};
            out_last_reg <= is_last;
            out_chg_reg  <= is_last && (chg_acc_reg || chg);
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = {2'b00, out_data_reg};
    assign m_tuser[0] = out_chg_reg;
    assign m_tlast    = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KMCU_ASSERT_NOW(a_chg_only_last, m_tvalid && m_tuser[0], m_tlast,
        "any_changed set on a result that is not the last")
    `KMCU_ASSERT_NOW(a_acc_only_run, acc_vld_reg, state_reg == kmcu_pkg::ST_RUN,
        "sum write-back outside the accumulate phase")
    `KMCU_ASSERT_NEXT(a_sums_cleared, clear_sums, sum_vld_reg == '0,
        "sum valid bits not cleared after finish")
    `KMCU_ASSERT_NEXT(a_idx_advance, out_load && !is_last,
        idx_reg == IDX_W'($past(idx_reg) + 1'b1),
        "finish walk skipped or repeated a cluster")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the k-means centroid update core.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_POINTS   = 65536;
    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused command code, block drops it

    localparam int IDLE_PCT     = 15;     // chance of a bubble on either side, in percent
    localparam int SETTLE_CYC   = 40;     // quiet cycles before a register write
    localparam int STALL_CYC    = 300;    // long hold-off of the center sink
    localparam int WATCHDOG_CYC = 4000;   // cycles without any transfer before giving up
    localparam int FILL_ITEMS   = 16;     // full-rate burst into one cluster
    localparam int RANDOM_ITEMS = 150;

    // One input transfer: command plus cluster and point.
    typedef struct {
        logic [1:0]         cmd;
        logic [5:0]         cluster;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_cmd_t;

    // One output transfer: a new center.
    typedef struct {
        logic [5:0]         index;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               changed;
        logic               last;
    } center_t;

    // Directed row. When typed is set, every center emitted by this row must equal
    // (ex, ey, ez) and the moved flag on the last one must equal echg.
    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  cluster;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        bit          typed;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [15:0] ez;
        bit          echg;
    } directed_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;    // cluster[5:0], point_x[21:6], point_y[37:22],
                                   // point_z[53:38], zero fill [55:54]
    logic [1:0]  s_tuser  = '0;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // center_index[5:0], center_x[21:6],
                                   // center_y[37:22], center_z[53:38], zero fill
    logic [0:0]  m_tuser;          // any_changed[0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [0:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    kmeans_centroid_update_core #(
        .MAX_CLUSTERS(MAX_CLUSTERS),
        .MAX_POINTS  (MAX_POINTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the block state: per-cluster lane sums, member counts and
    // stored centers, plus the num_clusters register.
    logic signed [31:0]        acc_x [MAX_CLUSTERS];
    logic signed [31:0]        acc_y [MAX_CLUSTERS];
    logic signed [31:0]        acc_z [MAX_CLUSTERS];
    logic [16:0]               members [MAX_CLUSTERS];
    logic signed [15:0]        ctr_x [MAX_CLUSTERS];
    logic signed [15:0]        ctr_y [MAX_CLUSTERS];
    logic signed [15:0]        ctr_z [MAX_CLUSTERS];
    logic [kmcu_pkg::NC_W-1:0] k_setting;

    center_t       centers_due[$];      // centers predicted but not yet seen on m_*
    directed_row_t dir_rows[18];
    int            mismatches     = 0;
    bit            idle_on        = 1'b1;
    int            stall_requests = 0;  // bump to request a stall of the center sink

    initial
    begin : clock_gen
        forever #4 clk = ~clk;
    end

    // Clamp the register to the usable cluster range.
    function automatic int clusters_in_use();
        int k;
        k = int'(k_setting);
        if (k < 1) k = 1;
        if (k > MAX_CLUSTERS) k = MAX_CLUSTERS;
        return k;
    endfunction

    // Truncating mean of one lane; an empty cluster keeps its center.
    function automatic logic signed [15:0] lane_mean(input logic signed [31:0] total,
                                                     input logic [16:0] count,
                                                     input logic signed [15:0] keep);
        int s;
        int n;
        int q;
        s = total;
        n = int'(count);
        if (n == 0) return keep;
        q = s / n;
        return q[15:0];
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            acc_x[i]   = '0;
            acc_y[i]   = '0;
            acc_z[i]   = '0;
            members[i] = '0;
        end
    endfunction

    // Advance the mirror by one accepted transfer and queue the centers it emits.
    // Return 1 when the transfer did anything at all.
    function automatic bit apply_command(input point_cmd_t pc);
        int                 k;
        int                 c;
        bit                 moved;
        logic signed [15:0] nx [MAX_CLUSTERS];
        logic signed [15:0] ny [MAX_CLUSTERS];
        logic signed [15:0] nz [MAX_CLUSTERS];
        center_t            ctr;
        k     = clusters_in_use();
        c     = int'(pc.cluster);
        moved = 1'b0;
        case (pc.cmd)
            kmcu_pkg::CMD_ACC:
            begin
                // drop points for unused clusters and for full clusters
                if (c < k && members[c] < MAX_POINTS)
                begin
                    acc_x[c]   = acc_x[c] + pc.x;
                    acc_y[c]   = acc_y[c] + pc.y;
                    acc_z[c]   = acc_z[c] + pc.z;
                    members[c] = members[c] + 1'b1;
                    return 1'b1;
                end
            end
            kmcu_pkg::CMD_LOAD:
            begin
                // load touches the center only, sums stay
                if (c < k)
                begin
                    ctr_x[c] = pc.x;
                    ctr_y[c] = pc.y;
                    ctr_z[c] = pc.z;
                    return 1'b1;
                end
            end
            kmcu_pkg::CMD_FINISH:
            begin
                for (int i = 0; i < k; i++)
                begin
                    nx[i] = lane_mean(acc_x[i], members[i], ctr_x[i]);
                    ny[i] = lane_mean(acc_y[i], members[i], ctr_y[i]);
                    nz[i] = lane_mean(acc_z[i], members[i], ctr_z[i]);
                    if (nx[i] != ctr_x[i] || ny[i] != ctr_y[i] || nz[i] != ctr_z[i])
                        moved = 1'b1;
                end
                for (int i = 0; i < k; i++)
                begin
                    ctr.index   = 6'(i);
                    ctr.x       = nx[i];
                    ctr.y       = ny[i];
                    ctr.z       = nz[i];
                    ctr.last    = (i == k - 1);
                    ctr.changed = ctr.last && moved;
                    centers_due.push_back(ctr);
                    ctr_x[i] = nx[i];
                    ctr_y[i] = ny[i];
                    ctr_z[i] = nz[i];
                end
                clear_sums();
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Check one center transfer against the oldest prediction.
    function automatic void check_center();
        center_t want;
        center_t got;
        got.index   = m_tdata[5:0];
        got.x       = m_tdata[21:6];
        got.y       = m_tdata[37:22];
        got.z       = m_tdata[53:38];
        got.changed = m_tuser[0];
        got.last    = m_tlast;
        if (centers_due.size() == 0)
        begin
            $display("%0t: unexpected center, expected none, got index %0d", $time,
                     got.index);
            mismatches++;
            return;
        end
        want = centers_due.pop_front();
        compare_field("center_index", 32'(want.index), 32'(got.index));
        compare_field("center_x", 32'(want.x), 32'(got.x));
        compare_field("center_y", 32'(want.y), 32'(got.y));
        compare_field("center_z", 32'(want.z), 32'(got.z));
        compare_field("any_changed", 32'(want.changed), 32'(got.changed));
        compare_field("last_center", 32'(want.last), 32'(got.last));
    endfunction

    // Coordinate with extra weight on the extremes and on values near zero.
    function automatic logic [15:0] rand_coord();
        logic [3:0] r;
        r = 4'($urandom);
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return {{12{r[3]}}, r};
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one transfer, with random bubbles ahead of it, and hold it until taken.
    task automatic send_cmd(input point_cmd_t pc, output bit hit);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= pc.cmd;
        s_tdata  <= {2'b00, pc.z, pc.y, pc.x, pc.cluster};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        hit = apply_command(pc);
    endtask

    task automatic send_simple(input logic [1:0] cmd, input int cluster);
        point_cmd_t pc;
        bit         hit;
        pc.cmd     = cmd;
        pc.cluster = 6'(cluster);
        pc.x       = rand_coord();
        pc.y       = rand_coord();
        pc.z       = rand_coord();
        send_cmd(pc, hit);
    endtask

    // Stop offering, wait for every predicted center, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (centers_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; pready is always high.
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= kmcu_pkg::REG_NUM_CLUSTERS;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write num_clusters while idle, with junk in the upper data bits, and read it back.
    task automatic set_clusters(input logic [6:0] value);
        logic [31:0] wdata;
        logic [31:0] rd;
        wait_drained();
        wdata      = $urandom;
        wdata[6:0] = value;
        apb_access(1'b1, wdata, rd);
        k_setting = value;
        @(posedge clk);
        apb_access(1'b0, $urandom, rd);
        if (rd !== 32'(value))
        begin
            $display("%0t: num_clusters readback mismatch, expected %0d, got %0d",
                     $time, value, rd);
            mismatches++;
        end
    endtask

    // Center sink: check each transfer, then pick next cycle's tready. A stall
    // request holds tready low until the stall counter kept here runs down.
    initial
    begin : center_sink
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_center();
            if (stall_requests != stall_seen)
            begin
                stall_seen = stall_requests;
                stall_left = STALL_CYC;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYC)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        point_cmd_t pc;
        center_t    ctr;
        bit         hit;
        int         k;
        int         effective;
        int         round;
        int         len;
        int         pick;
        logic [6:0] nc_val;

        // Directed table, run at the reset setting of 16 clusters.
        dir_rows = '{
            // after reset every center is zero and nothing moves
            '{kmcu_pkg::CMD_FINISH, 6'd0,  16'h0000, 16'h0000, 16'h0000,
              1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{kmcu_pkg::CMD_LOAD,   6'd0,  16'h7FFF, 16'h8000, 16'h0000,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_LOAD,   6'd15, 16'h8000, 16'h7FFF, 16'hFFFF,
              1'b0, '0, '0, '0, 1'b0},
            // cluster out of range: load and accumulate both dropped
            '{kmcu_pkg::CMD_LOAD,   6'd63, 16'h0001, 16'h0001, 16'h0001,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_ACC,    6'd63, 16'h0005, 16'h0005, 16'h0005,
              1'b0, '0, '0, '0, 1'b0},
            // unused command dropped
            '{CMD_SPARE,            6'd0,  16'h1234, 16'h1234, 16'h1234,
              1'b0, '0, '0, '0, 1'b0},
            // opposite extremes: mean of -1 over 2 truncates to zero
            '{kmcu_pkg::CMD_ACC,    6'd0,  16'h7FFF, 16'h7FFF, 16'h7FFF,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_ACC,    6'd0,  16'h8000, 16'h8000, 16'h8000,
              1'b0, '0, '0, '0, 1'b0},
            // negative odd sums round toward zero
            '{kmcu_pkg::CMD_ACC,    6'd1,  16'hFFFD, 16'h0003, 16'hFFFF,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_ACC,    6'd1,  16'h0000, 16'h0000, 16'hFFFF,
              1'b0, '0, '0, '0, 1'b0},
            // load between points keeps the sums
            '{kmcu_pkg::CMD_LOAD,   6'd1,  16'h0064, 16'h00C8, 16'h012C,
              1'b0, '0, '0, '0, 1'b0},
            // mean equal to the stored center does not count as moved
            '{kmcu_pkg::CMD_ACC,    6'd15, 16'h8000, 16'h7FFF, 16'hFFFF,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_FINISH, 6'd0,  16'h0000, 16'h0000, 16'h0000,
              1'b0, '0, '0, '0, 1'b0},
            // all clusters empty: centers hold
            '{kmcu_pkg::CMD_FINISH, 6'd0,  16'h0000, 16'h0000, 16'h0000,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_ACC,    6'd16, 16'h4444, 16'h4444, 16'h4444,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_ACC,    6'd2,  16'hAAAA, 16'h5555, 16'hFFFF,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_ACC,    6'd2,  16'h5555, 16'hAAAA, 16'h0000,
              1'b0, '0, '0, '0, 1'b0},
            '{kmcu_pkg::CMD_FINISH, 6'd0,  16'h0000, 16'h0000, 16'h0000,
              1'b0, '0, '0, '0, 1'b0}
        };

        // Mirror the reset state, hold reset, then release it.
        clear_sums();
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            ctr_x[i] = '0;
            ctr_y[i] = '0;
            ctr_z[i] = '0;
        end
        k_setting = kmcu_pkg::NC_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            pc.cmd     = dir_rows[r].cmd;
            pc.cluster = dir_rows[r].cluster;
            pc.x       = dir_rows[r].x;
            pc.y       = dir_rows[r].y;
            pc.z       = dir_rows[r].z;
            send_cmd(pc, hit);
            // Overwrite the centers just queued with the typed values.
            if (dir_rows[r].typed)
                for (int j = 1; j <= clusters_in_use(); j++)
                begin
                    ctr         = centers_due[centers_due.size() - j];
                    ctr.x       = dir_rows[r].ex;
                    ctr.y       = dir_rows[r].ey;
                    ctr.z       = dir_rows[r].ez;
                    ctr.changed = ctr.last && dir_rows[r].echg;
                    centers_due[centers_due.size() - j] = ctr;
                end
        end

        // Back pressure: hold the sink off while points and two finishes go in,
        // so the output slot fills and the input stalls behind the pass.
        wait_drained();
        stall_requests <= stall_requests + 1;
        k = clusters_in_use();
        repeat (30) send_simple(kmcu_pkg::CMD_ACC, $urandom_range(k - 1));
        send_simple(kmcu_pkg::CMD_FINISH, 0);
        repeat (20) send_simple(kmcu_pkg::CMD_ACC, $urandom_range(k - 1));
        send_simple(kmcu_pkg::CMD_FINISH, 0);

        // Burst of extreme points into cluster 0 at full rate on both sides,
        // with a few points for cluster 1 mixed in.
        set_clusters(7'd2);
        idle_on = 1'b0;
        for (int n = 0; n < FILL_ITEMS; n++)
        begin
            pc.cmd     = kmcu_pkg::CMD_ACC;
            pc.cluster = 6'd0;
            pc.x       = (n < FILL_ITEMS - 4) ? 16'h7FFF : 16'h8000;
            pc.y       = (n < FILL_ITEMS - 4) ? 16'h8000 : 16'h7FFF;
            pc.z       = rand_coord();
            send_cmd(pc, hit);
            if (n % 4 == 0)
                send_simple(kmcu_pkg::CMD_ACC, 1);
        end
        send_simple(kmcu_pkg::CMD_FINISH, 0);
        idle_on = 1'b1;

        // Random rounds: set k, then a well-formed batch of loads, points and
        // finishes with some noise, closed by a finish. Register extremes come first.
        effective = 0;
        round     = 0;
        while (effective < RANDOM_ITEMS)
        begin
            case (round)
                0:       nc_val = 7'd0;
                1:       nc_val = 7'd64;
                2:       nc_val = 7'd127;
                3:       nc_val = 7'd1;
                4:       nc_val = 7'd16;
                default: nc_val = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                           : 7'($urandom_range(1, 16));
            endcase
            set_clusters(nc_val);
            idle_on = (round != 4);   // one round with no bubbles on either side
            k       = clusters_in_use();
            len     = $urandom_range(8, 40);
            for (int n = 0; n < len; n++)
            begin
                pick       = $urandom_range(99);
                pc.x       = rand_coord();
                pc.y       = rand_coord();
                pc.z       = rand_coord();
                pc.cluster = 6'($urandom_range(k - 1));
                if (pick < 8)
                begin
                    pc.cmd     = $urandom_range(1) ? kmcu_pkg::CMD_ACC
                                                   : kmcu_pkg::CMD_LOAD;
                    pc.cluster = 6'($urandom_range(63, k));
                end
                else if (pick < 12)
                begin
                    pc.cmd     = CMD_SPARE;
                    pc.cluster = 6'($urandom_range(63));
                end
                else if (pick < 22)
                    pc.cmd = kmcu_pkg::CMD_LOAD;
                else if (pick < 25)
                    pc.cmd = kmcu_pkg::CMD_FINISH;
                else
                    pc.cmd = kmcu_pkg::CMD_ACC;
                send_cmd(pc, hit);
                if (hit)
                    effective++;
            end
            send_simple(kmcu_pkg::CMD_FINISH, 0);
            round++;
        end

        wait_drained();
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/kmcu_pkg.sv
rtl/core/kmcu_ram.sv
rtl/core/kmeans_centroid_update_core.sv
tb/tb_top.sv
